/* design/zt_pkg.sv */
package zt_pkg;

    localparam int WINDOW    = 256;
    localparam int ZONES     = 16;
    localparam int ROW_W     = $clog2(WINDOW);
    localparam int FILL_W    = $clog2(WINDOW + 1);
    localparam int COL_W     = 4;
    localparam int ADDR_W    = ROW_W + COL_W;
    localparam int MEM_DEPTH = WINDOW << COL_W;
    localparam int VAL_W     = 24;
    localparam logic [VAL_W-1:0] VAL_MAX = '1;

    typedef enum logic [2:0] {
        OP_FRAME_BEGIN = 3'd0,
        OP_ZONE_BEGIN  = 3'd1,
        OP_ZONE_END    = 3'd2,
        OP_FRAME_END   = 3'd3,
        OP_QUERY       = 3'd4
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [3:0]  zone;
        logic        zone_ok;
        logic [31:0] ts;
        logic [16:0] pct;
    } t_cmd;

endpackage

/* design/zt_in_if.sv */
interface zt_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  op;
    logic [3:0]  zone;
    logic [31:0] timestamp;
    logic [16:0] pct;

    modport source (output valid, op, zone, timestamp, pct, input ready);
    modport sink (input valid, op, zone, timestamp, pct, output ready);
endinterface

/* design/zt_out_if.sv */
interface zt_out_if;
    logic        valid;
    logic        ready;
    logic [23:0] value;
    logic [8:0]  sample_count;
    logic        within_budget;
    logic [31:0] frames_total;

    modport source (output valid, value, sample_count, within_budget, frames_total,
                    input ready);
    modport sink (input valid, value, sample_count, within_budget, frames_total,
                  output ready);
endinterface

/* design/zt_front.sv */
module zt_front
    import zt_pkg::*;
(
    zt_in_if.sink  i_in,
    input  logic   i_push_ready,
    output logic   o_push_valid,
    output t_cmd   o_push_cmd
);

    logic op_known;

    assign op_known     = (i_in.op <= OP_QUERY);
    assign i_in.ready   = i_push_ready;
    // unused opcodes are dropped here
    assign o_push_valid = i_in.valid && op_known;

    always_comb begin
        o_push_cmd.op      = t_op'(i_in.op);
        o_push_cmd.zone    = i_in.zone;
        o_push_cmd.zone_ok = ({1'b0, i_in.zone} < 5'(ZONES));
        o_push_cmd.ts      = i_in.timestamp;
        o_push_cmd.pct     = i_in.pct;
    end

endmodule

/* design/zt_queue.sv */
module zt_queue
    import zt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    output logic o_push_ready,
    input  t_cmd i_push_cmd,
    output logic o_pop_valid,
    input  logic i_pop_ready,
    output t_cmd o_pop_cmd
);

    t_cmd       r_slot [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;

    assign o_push_ready = (r_cnt != 2'd2);
    assign o_pop_valid  = (r_cnt != 2'd0);
    assign o_pop_cmd    = r_slot[r_rd];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr] <= i_push_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

endmodule

/* design/zt_back.sv */
module zt_back
    import zt_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cmd_valid,
    output logic             o_cmd_ready,
    input  t_cmd             i_cmd,
    input  logic [VAL_W-1:0] i_budget,
    zt_out_if.source         o_out
);

    typedef enum logic [3:0] {
        S_IDLE, S_FE, S_FE_WR, S_Q_SETUP, S_CAND_RD, S_CAND_LATCH,
        S_SCAN, S_CHECK, S_MUL, S_OUT
    } t_state;

    t_state              r_state;
    t_cmd                r_cmd;
    logic [31:0]         r_start [ZONES];
    logic [VAL_W-1:0]    r_accum [ZONES];
    logic [ROW_W-1:0]    r_head;
    logic [FILL_W-1:0]   r_fill;
    logic [31:0]         r_frames;
    logic [COL_W-1:0]    r_k;
    logic [ROW_W-1:0]    r_j;
    logic [ROW_W-1:0]    r_i;
    logic [ROW_W-1:0]    r_r1;
    logic [ROW_W-1:0]    r_r2;
    logic [15:0]         r_f;
    logic [FILL_W-1:0]   r_lt;
    logic [FILL_W-1:0]   r_eq;
    logic [VAL_W-1:0]    r_cand;
    logic [VAL_W-1:0]    r_a;
    logic [VAL_W-1:0]    r_b;
    logic [VAL_W+15:0]   r_prod;
    logic                r_out_valid;
    logic [VAL_W-1:0]    r_out_value;
    logic [8:0]          r_out_count;
    logic                r_out_within;
    logic [31:0]         r_out_frames;

    logic [VAL_W-1:0]    mem [MEM_DEPTH];
    logic [VAL_W-1:0]    r_rd;
    logic [ADDR_W-1:0]   rd_addr;
    logic                wr_en;
    logic [COL_W-1:0]    acc_idx;
    logic [VAL_W-1:0]    acc_rd;
    logic [31:0]         zone_d;
    logic [32:0]         zone_sum;
    logic [31:0]         frame_d;
    logic [FILL_W-1:0]   n_m1;
    logic [FILL_W+15:0]  idx;
    logic [FILL_W:0]     lt_x;
    logic [FILL_W:0]     hi_x;
    logic                hit1;
    logic                hit2;
    logic [VAL_W-1:0]    q_value;
    logic                out_free;

    function automatic logic [31:0] elapsed(input logic [31:0] now, input logic [31:0] start);
        logic [31:0] d;
        d = now - start;
        return d[31] ? 32'd0 : d;
    endfunction

    assign o_cmd_ready = (r_state == S_IDLE);
    assign out_free    = !r_out_valid || o_out.ready;
    assign wr_en       = (r_state == S_FE_WR);
    assign acc_idx     = wr_en ? r_k : r_cmd.zone;
    assign acc_rd      = r_accum[acc_idx];
    assign zone_d      = elapsed(r_cmd.ts, r_start[r_cmd.zone]);
    assign zone_sum    = 33'(acc_rd) + 33'(zone_d);
    assign frame_d     = elapsed(r_cmd.ts, r_start[0]);
    assign n_m1        = r_fill - FILL_W'(1);
    assign idx         = (FILL_W+16)'(r_cmd.pct[15:0]) * (FILL_W+16)'(n_m1);
    assign lt_x        = (FILL_W+1)'(r_lt);
    assign hi_x        = lt_x + (FILL_W+1)'(r_eq);
    assign hit1        = (lt_x <= (FILL_W+1)'(r_r1)) && ((FILL_W+1)'(r_r1) < hi_x);
    assign hit2        = (lt_x <= (FILL_W+1)'(r_r2)) && ((FILL_W+1)'(r_r2) < hi_x);
    assign q_value     = r_a + VAL_W'((r_prod + (VAL_W+16)'(32768)) >> 16);

    always_comb begin
        unique case (r_state)
            S_CAND_RD:    rd_addr = {r_j, r_cmd.zone};
            S_CAND_LATCH: rd_addr = {ROW_W'(0), r_cmd.zone};
            S_SCAN:       rd_addr = {r_i + ROW_W'(1), r_cmd.zone};
            default:      rd_addr = {r_head, r_k};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[{r_head, r_k}] <= acc_rd;
        end
        r_rd <= mem[rd_addr];
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.value         = r_out_value;
    assign o_out.sample_count  = r_out_count;
    assign o_out.within_budget = r_out_within;
    assign o_out.frames_total  = r_out_frames;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_fill      <= '0;
            r_frames    <= '0;
            r_out_valid <= 1'b0;
            for (int z = 0; z < ZONES; z++) begin
                r_start[z] <= '0;
                r_accum[z] <= '0;
            end
        end else begin
            if (o_out.valid && o_out.ready && !(r_state == S_OUT && out_free)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd <= i_cmd;
                        r_k   <= '0;
                        unique case (i_cmd.op)
                            OP_FRAME_BEGIN: begin
                                for (int z = 0; z < ZONES; z++) begin
                                    r_accum[z] <= '0;
                                end
                                r_start[0] <= i_cmd.ts;
                            end
                            OP_ZONE_BEGIN: begin
                                if (i_cmd.zone_ok) begin
                                    r_start[i_cmd.zone] <= i_cmd.ts;
                                end
                            end
                            OP_ZONE_END: r_state <= S_FE;
                            OP_FRAME_END: r_state <= S_FE;
                            OP_QUERY: r_state <= S_Q_SETUP;
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_FE: begin
                    if (r_cmd.op == OP_ZONE_END) begin
                        if (r_cmd.zone_ok) begin
                            r_accum[r_cmd.zone] <= (zone_sum > 33'(VAL_MAX)) ? VAL_MAX
                                                                            : zone_sum[VAL_W-1:0];
                        end
                        r_state <= S_IDLE;
                    end else begin
                        r_accum[0] <= (frame_d > 32'(VAL_MAX)) ? VAL_MAX
                                                               : frame_d[VAL_W-1:0];
                        r_state    <= S_FE_WR;
                    end
                end
                S_FE_WR: begin
                    r_k <= r_k + COL_W'(1);
                    if (r_k == COL_W'(ZONES - 1)) begin
                        r_head   <= (r_head == ROW_W'(WINDOW - 1)) ? '0 : r_head + ROW_W'(1);
                        r_fill   <= (r_fill == FILL_W'(WINDOW)) ? r_fill
                                                                : r_fill + FILL_W'(1);
                        r_frames <= r_frames + 32'd1;
                        r_state  <= S_IDLE;
                    end
                end
                S_Q_SETUP: begin
                    r_j <= '0;
                    r_a <= '0;
                    r_b <= '0;
                    if (r_fill == '0 || !r_cmd.zone_ok) begin
                        r_f     <= '0;
                        r_state <= S_MUL;
                    end else if (r_cmd.pct[16]) begin
                        r_r1    <= n_m1[ROW_W-1:0];
                        r_r2    <= n_m1[ROW_W-1:0];
                        r_f     <= '0;
                        r_state <= S_CAND_RD;
                    end else begin
                        r_r1    <= idx[16 +: ROW_W];
                        r_r2    <= idx[16 +: ROW_W] + ROW_W'(1);
                        r_f     <= idx[15:0];
                        r_state <= S_CAND_RD;
                    end
                end
                S_CAND_RD: r_state <= S_CAND_LATCH;
                S_CAND_LATCH: begin
                    r_cand  <= r_rd;
                    r_lt    <= '0;
                    r_eq    <= '0;
                    r_i     <= '0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (r_rd < r_cand) begin
                        r_lt <= r_lt + FILL_W'(1);
                    end
                    if (r_rd == r_cand) begin
                        r_eq <= r_eq + FILL_W'(1);
                    end
                    r_i <= r_i + ROW_W'(1);
                    if (r_i == n_m1[ROW_W-1:0]) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (hit1) begin
                        r_a <= r_cand;
                    end
                    if (hit2) begin
                        r_b <= r_cand;
                    end
                    r_j <= r_j + ROW_W'(1);
                    r_state <= (r_j == n_m1[ROW_W-1:0]) ? S_MUL : S_CAND_RD;
                end
                S_MUL: begin
                    // b >= a whenever f is nonzero, so a*(1-f) + b*f = a + (b-a)*f
                    r_prod  <= (VAL_W+16)'(r_b - r_a) * (VAL_W+16)'(r_f);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_value  <= q_value;
                        r_out_count  <= 9'(r_fill);
                        r_out_within <= (q_value <= i_budget);
                        r_out_frames <= r_frames;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

/* design/zone_time_window_percentile.sv */
// Frame begin and zone begin retire in S_IDLE; zone end retires through S_FE.
// Frame end goes through S_FE and then S_FE_WR, one window write per zone.
// Query: each of the n rows held is ranked as a candidate by a selection scan over the
// single-port window RAM, then S_MUL and S_OUT. Input takes a beat each cycle
// while the 2-deep queue has room. Reset (synchronous, active low) clears zones, head, fill,
// frame count, budget to all ones; the window RAM is not cleared.
module zone_time_window_percentile
    import zt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    zt_in_if.sink       i_in,
    zt_out_if.source    o_out,
    input  logic        i_cfg_we,
    input  logic [23:0] i_cfg_wdata
);

    logic             push_valid;
    logic             push_ready;
    t_cmd             push_cmd;
    logic             pop_valid;
    logic             pop_ready;
    t_cmd             pop_cmd;
    logic [VAL_W-1:0] r_budget;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_budget <= VAL_MAX;
        end else if (i_cfg_we) begin
            r_budget <= i_cfg_wdata;
        end
    end

    zt_front u_front (
        .i_in         (i_in),
        .i_push_ready (push_ready),
        .o_push_valid (push_valid),
        .o_push_cmd   (push_cmd)
    );

    zt_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_cmd   (push_cmd),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_cmd    (pop_cmd)
    );

    zt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (pop_valid),
        .o_cmd_ready (pop_ready),
        .i_cmd       (pop_cmd),
        .i_budget    (r_budget),
        .o_out       (o_out)
    );

endmodule
